FILE: rtl/smt_pkg.sv
// Package: request codes, status codes, item structs and sequencer states for the mark table.
`default_nettype none
package smt_pkg;

    localparam logic [3:0] REQ_ADD        = 4'd0;
    localparam logic [3:0] REQ_DEL_AT     = 4'd1;
    localparam logic [3:0] REQ_DEL_TYPE   = 4'd2;
    localparam logic [3:0] REQ_DEL_RANGE  = 4'd3;
    localparam logic [3:0] REQ_DEL_WEAK   = 4'd4;
    localparam logic [3:0] REQ_DEL_BEFORE = 4'd5;
    localparam logic [3:0] REQ_DEL_AFTER  = 4'd6;
    localparam logic [3:0] REQ_CLEAR      = 4'd7;
    localparam logic [3:0] REQ_GET        = 4'd8;
    localparam logic [3:0] REQ_PREV       = 4'd9;
    localparam logic [3:0] REQ_NEXT       = 4'd10;
    localparam logic [3:0] REQ_AROUND     = 4'd11;
    localparam logic [3:0] REQ_COUNT      = 4'd12;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_PAIR_DEL = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic [7:0] ANY_TYPE    = 8'hFF;
    localparam logic [7:0] HIGH_NIBBLE = 8'hF0;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [23:0] position;
        logic [23:0] range_end;
        logic [7:0]  type_code;
        logic [7:0]  type_mask;
        logic [23:0] window;
        logic        in_broadcast;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [23:0] out_position;
        logic [7:0]  out_type;
        logic        out_broadcast;
        logic [6:0]  tally;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [23:0] position;
        logic [7:0]  mtype;
        logic        broadcast;
    } mark_t;

    // Sequencer states: one table entry is read per SCAN cycle
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/smt_store.sv
// Mark store: one memory with a registered read port and one write port.
`default_nettype none
module smt_store #(
    parameter int CAPACITY = 64,
    parameter int IW = 6
) (
    input  wire logic                clk,
    input  wire logic [IW-1:0]       rd_addr,
    output smt_pkg::mark_t           rd_data,
    input  wire logic                wr_en,
    input  wire logic [IW-1:0]       wr_addr,
    input  wire smt_pkg::mark_t      wr_data
);

    smt_pkg::mark_t mem [CAPACITY];

    // Write one entry, read one entry, both clocked
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: rtl/sorted_mark_table.sv
// Top level: sorted mark table with a sequencer over one memory.
// Each item is one sweep through the table: the sequencer reads entry i and
// writes at most one entry per cycle, so compaction (deletes) and shifting
// (add) happen in the same walk. The sweep is paced by the single read port of
// the mark memory: entries are read in order through the SCAN state, then
// WAIT and DONE follow; busy is high outside IDLE and the result is shown
// for one cycle on done. The receiver cannot stall; a new item can be taken
// in the same cycle that shows done.
`default_nettype none
module sorted_mark_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire smt_pkg::req_t req,
    output logic              busy,
    output logic              done,
    output smt_pkg::rsp_t     rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1) + 1;

    smt_pkg::state_t state_reg, state_next;
    smt_pkg::req_t   req_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rd_reg, rd_next;     // read index
    logic [CW-1:0]   wr_reg, wr_next;     // write index (compaction / insert)
    logic            vld_reg, vld_next;   // read data valid for index rd_reg-1
    logic            ins_reg, ins_next;   // new mark already placed
    smt_pkg::mark_t  carry_reg, carry_next; // entry displaced by insert
    logic            carry_v_reg, carry_v_next;
    logic            hit_reg, hit_next;
    smt_pkg::mark_t  hit_mark_reg, hit_mark_next;
    logic            prv_reg, prv_next;
    smt_pkg::mark_t  prv_mark_reg, prv_mark_next;
    logic            nxt_reg, nxt_next;
    smt_pkg::mark_t  nxt_mark_reg, nxt_mark_next;
    logic [CW-1:0]   tal_reg, tal_next;
    logic [1:0]      stat_reg, stat_next;
    logic            exact_reg, exact_next; // add found a mark at the position
    logic            pair_reg, pair_next;
    smt_pkg::mark_t  rd_data;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    smt_pkg::mark_t  wr_data;
    smt_pkg::rsp_t   rsp_reg, rsp_next;
    logic            done_reg, done_next;

    smt_store #(.CAPACITY(CAPACITY), .IW(IW)) u_store (
        .clk     (clk),
        .rd_addr (rd_reg[IW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smt_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == smt_pkg::S_IDLE)
        begin
            req_reg <= req;
        end
        rd_reg       <= rd_next;
        wr_reg       <= wr_next;
        vld_reg      <= vld_next;
        ins_reg      <= ins_next;
        carry_reg    <= carry_next;
        carry_v_reg  <= carry_v_next;
        hit_reg      <= hit_next;
        hit_mark_reg <= hit_mark_next;
        prv_reg      <= prv_next;
        prv_mark_reg <= prv_mark_next;
        nxt_reg      <= nxt_next;
        nxt_mark_reg <= nxt_mark_next;
        tal_reg      <= tal_next;
        stat_reg     <= stat_next;
        exact_reg    <= exact_next;
        pair_reg     <= pair_next;
        rsp_reg      <= rsp_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            smt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = smt_pkg::S_SCAN;
                end
            end
            smt_pkg::S_SCAN:
            begin
                if (rd_reg >= count_reg)
                begin
                    state_next = smt_pkg::S_WAIT;
                end
            end
            smt_pkg::S_WAIT: state_next = smt_pkg::S_DONE;
            smt_pkg::S_DONE: state_next = smt_pkg::S_IDLE;
            default:         state_next = smt_pkg::S_IDLE;
        endcase
    end

    // Datapath: process the entry on the store output, one per cycle
    always_comb
    begin
        logic [23:0]   p;
        logic [7:0]    t;
        logic          del;
        logic          keep_write;
        smt_pkg::mark_t cur;
        smt_pkg::mark_t newm;
        logic [23:0]   dp;
        logic [23:0]   dn;
        logic          pm;
        logic          pick_n;
        logic          have_pick;
        smt_pkg::mark_t pk;
        logic [23:0]   dk;
        logic          matchp;
        logic          full;

        rd_next       = rd_reg;
        wr_next       = wr_reg;
        vld_next      = 1'b0;
        ins_next      = ins_reg;
        carry_next    = carry_reg;
        carry_v_next  = carry_v_reg;
        hit_next      = hit_reg;
        hit_mark_next = hit_mark_reg;
        prv_next      = prv_reg;
        prv_mark_next = prv_mark_reg;
        nxt_next      = nxt_reg;
        nxt_mark_next = nxt_mark_reg;
        tal_next      = tal_reg;
        stat_next     = stat_reg;
        exact_next    = exact_reg;
        pair_next     = pair_reg;
        count_next    = count_reg;
        rsp_next      = rsp_reg;
        done_next     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = wr_reg[IW-1:0];
        wr_data       = rd_data;
        p             = rd_data.position;
        t             = rd_data.mtype;
        del           = 1'b0;
        keep_write    = 1'b0;
        cur           = rd_data;
        newm.position  = req_reg.position;
        newm.mtype     = req_reg.type_code;
        newm.broadcast = req_reg.in_broadcast;
        dp = '0; dn = '0; pm = 1'b0; pick_n = 1'b0; have_pick = 1'b0;
        pk = prv_mark_reg; dk = '0; matchp = 1'b0; full = 1'b0;

        case (state_reg)
            smt_pkg::S_IDLE:
            begin
                rd_next      = '0;
                wr_next      = '0;
                ins_next     = 1'b0;
                carry_v_next = 1'b0;
                hit_next     = 1'b0;
                prv_next     = 1'b0;
                nxt_next     = 1'b0;
                tal_next     = '0;
                stat_next    = smt_pkg::ST_OK;
                exact_next   = 1'b0;
                pair_next    = 1'b0;
            end
            smt_pkg::S_SCAN, smt_pkg::S_WAIT:
            begin
                // Advance the read index
                if (state_reg == smt_pkg::S_SCAN)
                begin
                    vld_next  = (rd_reg < count_reg);
                    rd_next   = rd_reg + 1'b1;
                end
                if (vld_reg)
                begin
                    // Classify the entry on the store output
                    case (req_reg.req_type)
                        smt_pkg::REQ_DEL_AT:
                            del = (p == req_reg.position);
                        smt_pkg::REQ_DEL_TYPE:
                            del = ((t & req_reg.type_mask) == req_reg.type_code);
                        smt_pkg::REQ_DEL_RANGE:
                            del = (p >= req_reg.position) && (p <= req_reg.range_end)
                                && ((t & smt_pkg::HIGH_NIBBLE) == req_reg.type_code);
                        smt_pkg::REQ_DEL_WEAK:
                            del = (p > req_reg.position) && (p < req_reg.range_end)
                                && (t < (req_reg.type_code & smt_pkg::HIGH_NIBBLE));
                        smt_pkg::REQ_DEL_BEFORE:
                            del = (p < req_reg.position);
                        smt_pkg::REQ_DEL_AFTER:
                            del = (p > req_reg.position);
                        smt_pkg::REQ_ADD:
                            del = (p == req_reg.position) && (t != req_reg.type_code)
                                && ((t & smt_pkg::HIGH_NIBBLE)
                                    == (req_reg.type_code & smt_pkg::HIGH_NIBBLE));
                        default: del = 1'b0;
                    endcase

                    case (req_reg.req_type)
                        smt_pkg::REQ_DEL_AT, smt_pkg::REQ_DEL_TYPE,
                        smt_pkg::REQ_DEL_RANGE, smt_pkg::REQ_DEL_WEAK,
                        smt_pkg::REQ_DEL_BEFORE, smt_pkg::REQ_DEL_AFTER:
                        begin
                            // Compact: keep survivors, drop hits
                            if (del)
                            begin
                                hit_next = 1'b1;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_data = cur;
                                wr_next = wr_reg + 1'b1;
                            end
                        end
                        smt_pkg::REQ_ADD:
                        begin
                            if (del)
                            begin
                                pair_next = 1'b1;
                                exact_next = 1'b1;
                            end
                            else if (p == req_reg.position)
                            begin
                                exact_next = 1'b1;
                                if (req_reg.type_code > t)
                                begin
                                    cur = newm;
                                end
                                hit_mark_next = cur;
                                wr_en   = 1'b1;
                                wr_data = cur;
                                wr_next = wr_reg + 1'b1;
                            end
                            else
                            begin
                                keep_write = 1'b1;
                            end
                            if (keep_write)
                            begin
                                wr_en   = 1'b1;
                                wr_next = wr_reg + 1'b1;
                                if (!ins_reg && p > req_reg.position
                                    && !exact_reg && count_reg < CW'(CAPACITY))
                                begin
                                    // Place the new mark, carry this entry on
                                    wr_data      = newm;
                                    hit_mark_next = newm;
                                    ins_next     = 1'b1;
                                    carry_next   = cur;
                                    carry_v_next = 1'b1;
                                end
                                else if (carry_v_reg)
                                begin
                                    wr_data    = carry_reg;
                                    carry_next = cur;
                                end
                                else
                                begin
                                    wr_data = cur;
                                end
                            end
                            else if (carry_v_reg && pair_next)
                            begin
                                wr_en = 1'b0;
                            end
                        end
                        smt_pkg::REQ_GET, smt_pkg::REQ_AROUND:
                        begin
                            if (p == req_reg.position)
                            begin
                                hit_next      = 1'b1;
                                hit_mark_next = cur;
                            end
                        end
                        default: ;
                    endcase

                    // Prev / next candidates
                    matchp = (req_reg.type_code == smt_pkg::ANY_TYPE)
                        || ((t & req_reg.type_mask) == req_reg.type_code);
                    if (p < req_reg.position && matchp)
                    begin
                        prv_next      = 1'b1;
                        prv_mark_next = cur;
                    end
                    if (p > req_reg.position && matchp && !nxt_reg)
                    begin
                        nxt_next      = 1'b1;
                        nxt_mark_next = cur;
                    end
                    if ((t & req_reg.type_mask) == req_reg.type_code)
                    begin
                        tal_next = tal_reg + 1'b1;
                    end
                end
            end
            smt_pkg::S_DONE:
            begin
                // Tail of add: place the new mark or the carried entry; clear and deletes set the count
                full = 1'b0;
                if (req_reg.req_type == smt_pkg::REQ_ADD)
                begin
                    if (pair_reg)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    else if (!exact_reg)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            full = 1'b1;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = wr_reg[IW-1:0];
                            wr_data = ins_reg ? carry_reg : newm;
                            if (!ins_reg)
                            begin
                                hit_mark_next = newm;
                            end
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                else if (req_reg.req_type == smt_pkg::REQ_CLEAR)
                begin
                    count_next = '0;
                end
                else if (req_reg.req_type >= smt_pkg::REQ_DEL_AT
                         && req_reg.req_type <= smt_pkg::REQ_DEL_AFTER)
                begin
                    count_next = wr_reg;
                end

                // Build the result
                rsp_next = '0;
                done_next = 1'b1;
                case (req_reg.req_type)
                    smt_pkg::REQ_ADD:
                    begin
                        if (pair_reg)
                        begin
                            rsp_next.status = smt_pkg::ST_PAIR_DEL;
                        end
                        else if (full)
                        begin
                            rsp_next.status = smt_pkg::ST_FULL;
                        end
                        else
                        begin
                            rsp_next.found = 1'b1;
                            pk = exact_reg ? hit_mark_reg : (ins_reg ? hit_mark_reg : newm);
                        end
                    end
                    smt_pkg::REQ_DEL_AT:
                    begin
                        if (!hit_reg)
                        begin
                            rsp_next.status = smt_pkg::ST_NONE;
                        end
                    end
                    smt_pkg::REQ_GET:
                    begin
                        rsp_next.found = hit_reg;
                        pk = hit_mark_reg;
                        if (!hit_reg)
                        begin
                            rsp_next.status = smt_pkg::ST_NONE;
                        end
                    end
                    smt_pkg::REQ_PREV:
                    begin
                        rsp_next.found = prv_reg;
                        pk = prv_mark_reg;
                        if (!prv_reg)
                        begin
                            rsp_next.status = smt_pkg::ST_NONE;
                        end
                    end
                    smt_pkg::REQ_NEXT:
                    begin
                        rsp_next.found = nxt_reg;
                        pk = nxt_mark_reg;
                        if (!nxt_reg)
                        begin
                            rsp_next.status = smt_pkg::ST_NONE;
                        end
                    end
                    smt_pkg::REQ_AROUND:
                    begin
                        pm = hit_reg && ((hit_mark_reg.mtype & req_reg.type_mask)
                            == (req_reg.type_code & req_reg.type_mask));
                        dp = req_reg.position - prv_mark_reg.position;
                        dn = nxt_mark_reg.position - req_reg.position;
                        pick_n = !prv_reg || (nxt_reg && dp > dn);
                        have_pick = prv_reg || nxt_reg;
                        dk = pick_n ? dn : dp;
                        if (pm)
                        begin
                            rsp_next.found = 1'b1;
                            pk = hit_mark_reg;
                        end
                        else if (have_pick && dk <= req_reg.window)
                        begin
                            rsp_next.found = 1'b1;
                            pk = pick_n ? nxt_mark_reg : prv_mark_reg;
                        end
                        else
                        begin
                            rsp_next.status = smt_pkg::ST_NONE;
                        end
                    end
                    default: ;
                endcase
                if (rsp_next.found)
                begin
                    rsp_next.out_position  = pk.position;
                    rsp_next.out_type      = pk.mtype;
                    rsp_next.out_broadcast = pk.broadcast;
                end
                if (req_reg.req_type == smt_pkg::REQ_COUNT
                    && req_reg.type_code != smt_pkg::ANY_TYPE)
                begin
                    rsp_next.tally = tal_reg[6:0];
                end
                else
                begin
                    rsp_next.tally = count_next[6:0];
                end
            end
            default: ;
        endcase
    end

    // Drive outputs
    always_comb
    begin
        busy = (state_reg != smt_pkg::S_IDLE);
        done = done_reg;
        rsp  = rsp_reg;
    end

endmodule
`default_nettype wire
